/* design/cfr_pkg.sv */
`default_nettype none

package cfr_pkg;

   // Fixed widths of the beat payloads.
   localparam int MAG_BITS    = 64;
   localparam int DEPTH_BITS  = 5;
   localparam int STATUS_BITS = 2;

   // Default fixed-point and result sizes.
   localparam int FRACTION_BITS_DEF = 32;
   localparam int RESULT_BITS_DEF   = 32;

   // Early stop once remainder * 2^STOP_SHIFT is below the divisor.
   localparam int STOP_SHIFT = 33;

   // Depth register value after reset.
   localparam logic [DEPTH_BITS-1:0] DEPTH_RESET = 5'd10;

   // Result status codes.
   localparam logic [STATUS_BITS-1:0] STATUS_OK   = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_ZERO = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_SAT  = 2'd2;

endpackage

`default_nettype wire

/* design/cfr_req_if.sv */
`default_nettype none

// Request channel: one value to rationalize per beat.
interface cfr_req_if import cfr_pkg::*;;
   logic                valid;
   logic                ready;
   logic                sign;
   logic [MAG_BITS-1:0] magnitude;

   modport source (output valid, sign, magnitude, input ready);
   modport sink   (input valid, sign, magnitude, output ready);
endinterface

`default_nettype wire

/* design/cfr_rsp_if.sv */
`default_nettype none

// Response channel: one rational approximation per beat.
interface cfr_rsp_if import cfr_pkg::*; #(
   parameter int RESULT_BITS = RESULT_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [RESULT_BITS-1:0] numerator;
   logic        [RESULT_BITS-2:0] denominator;
   logic        [STATUS_BITS-1:0] status;

   modport source (output valid, numerator, denominator, status, input ready);
   modport sink   (input valid, numerator, denominator, status, output ready);
endinterface

`default_nettype wire

/* design/continued_fraction_rationalizer_core.sv */
`default_nettype none

// Channel   Direction  Beat contents
// req_chan  in         sign, magnitude (unsigned fixed point)
// rsp_chan  out        numerator (signed), denominator, status
// csr       in         max_depth, written when csr_we is high
//
// Each continued fraction level is one 64-step pass of the shared restoring
// divider followed by a sequencing update, for at most max_depth + 1 levels.
// No new request beat is taken until the result of the last one is valid;
// a zero magnitude skips the divider. Reset is synchronous and returns the
// depth register to 10. req_chan is ready only while idle; a finished result
// waits in its sequencer state while the previous rsp_chan beat stalls.
module continued_fraction_rationalizer_core import cfr_pkg::*; #(
   parameter int FRACTION_BITS = FRACTION_BITS_DEF,
   parameter int RESULT_BITS   = RESULT_BITS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   cfr_req_if.sink               req_chan,
   cfr_rsp_if.source             rsp_chan,
   input  logic                  csr_we,
   input  logic [DEPTH_BITS-1:0] csr_wdata
);

   localparam logic [MAG_BITS-1:0] ONE_FIXED = MAG_BITS'(1) << FRACTION_BITS;
   localparam logic [RESULT_BITS-1:0] ONE_RES = RESULT_BITS'(1);
   localparam logic [RESULT_BITS:0] CAP_WIDE = (RESULT_BITS + 1)'(1) << (RESULT_BITS - 1);
   localparam logic [RESULT_BITS-2:0] LIMIT = '1;

   typedef enum logic [1:0] {
      S_IDLE,
      S_DIV,
      S_FIN
   } state_type;

   state_type state_ff, state_in;

   logic [DEPTH_BITS-1:0]  depth_ff, depth_in;
   logic [DEPTH_BITS-1:0]  lvl_ff, lvl_in;
   logic                   neg_ff, neg_in;
   logic                   zero_ff, zero_in;
   logic                   start_ff, start_in;
   logic [MAG_BITS-1:0]    dvd_ff, dvd_in;
   logic [MAG_BITS-1:0]    dsr_ff, dsr_in;
   logic [RESULT_BITS-1:0] p1_ff, p1_in, p2_ff, p2_in;
   logic [RESULT_BITS-1:0] q1_ff, q1_in, q2_ff, q2_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [RESULT_BITS-1:0] num_ff, num_in;
   logic [RESULT_BITS-2:0] den_ff, den_in;
   logic [STATUS_BITS-1:0] status_ff, status_in;

   logic                   unit_done;
   logic [MAG_BITS-1:0]    unit_rem;
   logic [RESULT_BITS-1:0] unit_acc_p;
   logic [RESULT_BITS-1:0] unit_acc_q;

   logic [RESULT_BITS:0]   sum_p;
   logic [RESULT_BITS:0]   sum_q;
   logic [RESULT_BITS-1:0] p_next;
   logic [RESULT_BITS-1:0] q_next;
   logic                   stop_early;
   logic                   p_sat;
   logic                   q_sat;
   logic [RESULT_BITS-1:0] num_mag;
   logic                   rsp_free;
   logic                   req_beat;

   // Shared divide and multiply-accumulate unit.
   cfr_div_unit #(
      .RESULT_BITS (RESULT_BITS)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (start_ff),
      .dividend  (dvd_ff),
      .divisor   (dsr_ff),
      .p_mult    (p1_ff),
      .q_mult    (q1_ff),
      .done      (unit_done),
      .remainder (unit_rem),
      .acc_p     (unit_acc_p),
      .acc_q     (unit_acc_q)
   );

   // Convergent update and early stop test at the end of a division.
   always_comb begin
      sum_p      = {1'b0, unit_acc_p} + {1'b0, p2_ff};
      sum_q      = {1'b0, unit_acc_q} + {1'b0, q2_ff};
      p_next     = (sum_p > CAP_WIDE) ? CAP_WIDE[RESULT_BITS-1:0] : sum_p[RESULT_BITS-1:0];
      q_next     = (sum_q > CAP_WIDE) ? CAP_WIDE[RESULT_BITS-1:0] : sum_q[RESULT_BITS-1:0];
      stop_early = unit_rem <= ((dsr_ff - MAG_BITS'(1)) >> STOP_SHIFT);
   end

   // Clamp and sign for the outgoing beat.
   always_comb begin
      p_sat   = p1_ff[RESULT_BITS-1];
      q_sat   = q1_ff[RESULT_BITS-1];
      num_mag = q_sat ? {1'b0, LIMIT} : q1_ff;
   end

   assign rsp_free = ~rsp_valid_ff | rsp_chan.ready;
   assign req_beat = req_chan.valid & (state_ff == S_IDLE);

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      depth_in     = csr_we ? csr_wdata : depth_ff;
      lvl_in       = lvl_ff;
      neg_in       = neg_ff;
      zero_in      = zero_ff;
      start_in     = 1'b0;
      dvd_in       = dvd_ff;
      dsr_in       = dsr_ff;
      p1_in        = p1_ff;
      p2_in        = p2_ff;
      q1_in        = q1_ff;
      q2_in        = q2_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      num_in       = num_ff;
      den_in       = den_ff;
      status_in    = status_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               neg_in  = req_chan.sign;
               zero_in = (req_chan.magnitude == '0);
               dvd_in  = ONE_FIXED;
               dsr_in  = req_chan.magnitude;
               p1_in   = ONE_RES;
               p2_in   = '0;
               q1_in   = '0;
               q2_in   = ONE_RES;
               lvl_in  = '0;
               if (req_chan.magnitude == '0) begin
                  state_in = S_FIN;
               end else begin
                  start_in = 1'b1;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            if (unit_done) begin
               p2_in = p1_ff;
               p1_in = p_next;
               q2_in = q1_ff;
               q1_in = q_next;
               if (stop_early || (lvl_ff == depth_ff)) begin
                  state_in = S_FIN;
               end else begin
                  dvd_in   = dsr_ff;
                  dsr_in   = unit_rem;
                  lvl_in   = lvl_ff + DEPTH_BITS'(1);
                  start_in = 1'b1;
               end
            end
         end
         S_FIN: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (zero_ff) begin
                  num_in    = '0;
                  den_in    = '0;
                  status_in = STATUS_ZERO;
               end else begin
                  num_in    = neg_ff ? (RESULT_BITS'(0) - num_mag) : num_mag;
                  den_in    = p_sat ? LIMIT : p1_ff[RESULT_BITS-2:0];
                  status_in = (p_sat | q_sat) ? STATUS_SAT : STATUS_OK;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         depth_ff     <= DEPTH_RESET;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         lvl_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         depth_ff     <= depth_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         lvl_ff       <= lvl_in;
      end
      neg_ff    <= neg_in;
      zero_ff   <= zero_in;
      dvd_ff    <= dvd_in;
      dsr_ff    <= dsr_in;
      p1_ff     <= p1_in;
      p2_ff     <= p2_in;
      q1_ff     <= q1_in;
      q2_ff     <= q2_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
      status_ff <= status_in;
   end

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.numerator   = num_ff;
   assign rsp_chan.denominator = den_ff;
   assign rsp_chan.status      = status_ff;

endmodule

`default_nettype wire

/* design/cfr_div_unit.sv */
`default_nettype none

// Restoring divider, one quotient bit per cycle, most significant first.
// Each quotient bit also feeds two saturating shift-add accumulators, so
// that at the end acc_p = min(a * p_mult, CAP) and acc_q likewise, where
// a is the quotient and CAP is 2^(RESULT_BITS-1).
module cfr_div_unit import cfr_pkg::*; #(
   parameter int RESULT_BITS = RESULT_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic [MAG_BITS-1:0]    dividend,
   input  logic [MAG_BITS-1:0]    divisor,
   input  logic [RESULT_BITS-1:0] p_mult,
   input  logic [RESULT_BITS-1:0] q_mult,
   output logic                   done,
   output logic [MAG_BITS-1:0]    remainder,
   output logic [RESULT_BITS-1:0] acc_p,
   output logic [RESULT_BITS-1:0] acc_q
);

   localparam int CNT_BITS = $clog2(MAG_BITS);
   localparam logic [CNT_BITS-1:0] CNT_LAST = CNT_BITS'(MAG_BITS - 1);
   localparam logic [RESULT_BITS:0] CAP_WIDE = (RESULT_BITS + 1)'(1) << (RESULT_BITS - 1);

   logic                   busy_ff, busy_in;
   logic                   done_ff, done_in;
   logic [CNT_BITS-1:0]    cnt_ff, cnt_in;
   logic [MAG_BITS-1:0]    rem_ff, rem_in;
   logic [MAG_BITS-1:0]    dvd_ff, dvd_in;
   logic [RESULT_BITS-1:0] accp_ff, accp_in;
   logic [RESULT_BITS-1:0] accq_ff, accq_in;

   logic [MAG_BITS:0]    rem_shift;
   logic [MAG_BITS:0]    trial;
   logic                 qbit;
   logic [RESULT_BITS:0] sum_p;
   logic [RESULT_BITS:0] sum_q;

   // One restoring step and the matching shift-add on both accumulators.
   always_comb begin
      rem_shift = {rem_ff, dvd_ff[MAG_BITS-1]};
      trial     = rem_shift - {1'b0, divisor};
      qbit      = ~trial[MAG_BITS];
      sum_p     = {accp_ff, 1'b0} + (qbit ? {1'b0, p_mult} : '0);
      sum_q     = {accq_ff, 1'b0} + (qbit ? {1'b0, q_mult} : '0);
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvd_in  = dvd_ff;
      accp_in = accp_ff;
      accq_in = accq_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvd_in  = dividend;
         accp_in = '0;
         accq_in = '0;
      end else if (busy_ff) begin
         rem_in  = qbit ? trial[MAG_BITS-1:0] : rem_shift[MAG_BITS-1:0];
         dvd_in  = {dvd_ff[MAG_BITS-2:0], 1'b0};
         accp_in = (sum_p > CAP_WIDE) ? CAP_WIDE[RESULT_BITS-1:0] : sum_p[RESULT_BITS-1:0];
         accq_in = (sum_q > CAP_WIDE) ? CAP_WIDE[RESULT_BITS-1:0] : sum_q[RESULT_BITS-1:0];
         cnt_in  = cnt_ff + CNT_BITS'(1);
         if (cnt_ff == CNT_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff  <= rem_in;
      dvd_ff  <= dvd_in;
      accp_ff <= accp_in;
      accq_ff <= accq_in;
   end

   assign done      = done_ff;
   assign remainder = rem_ff;
   assign acc_p     = accp_ff;
   assign acc_q     = accq_ff;

endmodule

`default_nettype wire
